[design/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, quiet while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[design/epv_pkg.sv]
package epv_pkg;

	// request kinds as they arrive on s_tuser
	localparam logic [1:0] REQ_EDGE  = 2'd0;
	localparam logic [1:0] REQ_QUERY = 2'd1;
	localparam logic [1:0] REQ_RESET = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	localparam int unsigned US_PER_S_W = 20;
	localparam logic [US_PER_S_W-1:0] US_PER_S = 20'd1000000;

	localparam int unsigned DIVIDEND_W = 52;
	localparam int unsigned DIVISOR_W  = 32;

	localparam int unsigned IN_DATA_W  = 56;
	localparam int unsigned OUT_DATA_W = 64;

	// operations after classification in the front end
	typedef enum logic [2:0] {
		OP_UP    = 3'd0,
		OP_DOWN  = 3'd1,
		OP_QUERY = 3'd2,
		OP_RESET = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] now_us;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} back_state_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

endpackage

[design/epv_front.sv]
module epv_front import epv_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic [1:0]           s_tuser,
	output logic                 q_valid,
	output item_t                q_item,
	input  logic                 q_pop
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	item_t          in_item;
	logic           push;
	logic           pop;

	// a query with a zero window behaves exactly like a plain read
	always_comb begin
		in_item.now_us = s_tdata[32:1];
		unique case (s_tuser)
			REQ_EDGE:  in_item.op = s_tdata[0] ? OP_UP : OP_DOWN;
			REQ_QUERY: in_item.op = (s_tdata[48:33] == 16'd0) ? OP_READ : OP_QUERY;
			REQ_RESET: in_item.op = OP_RESET;
			REQ_READ:  in_item.op = OP_READ;
		endcase
	end

	assign s_tready = (count_q != CW'(DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[design/epv_div.sv]
module epv_div import epv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  div_req_t              req,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int unsigned STEPS = 2;
	localparam int unsigned ITER  = DIVIDEND_W / STEPS;
	localparam int unsigned CNT_W = $clog2(ITER);

	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] dq_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W-1:0]  rem_d;
	logic [DIVIDEND_W-1:0] dq_d;

	// restoring division, two quotient bits per cycle; quotient shifts in at the bottom
	always_comb begin
		logic [DIVISOR_W:0]    r;
		logic [DIVIDEND_W-1:0] d;
		r = {1'b0, rem_q};
		d = dq_q;
		for (int i = 0; i < STEPS; i++) begin
			r = {r[DIVISOR_W-1:0], d[DIVIDEND_W-1]};
			d = {d[DIVIDEND_W-2:0], 1'b0};
			if (r >= {1'b0, dsr_q}) begin
				r = r - {1'b0, dsr_q};
				d[0] = 1'b1;
			end
		end
		rem_d = r[DIVISOR_W-1:0];
		dq_d  = d;
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dq_q  <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			dq_q  <= dq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

[design/epv_back.sv]
module epv_back import epv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  item_t                 q_item,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tuser,
	output div_req_t              div_req,
	input  logic                  div_done,
	input  logic [DIVIDEND_W-1:0] div_quot
);

	back_state_t state_q;
	back_state_t state_d;
	logic [31:0] position_q;
	logic [31:0] ref_pos_q;
	logic [31:0] ref_time_q;
	logic        neg_q;
	logic [31:0] mag_q;
	logic [31:0] dus_q;
	logic [31:0] now_q;
	logic        out_valid_q;
	logic [31:0] out_pos_q;
	logic [31:0] out_speed_q;
	logic        out_fresh_q;

	logic        slot_free;
	logic [31:0] dticks;
	logic [31:0] dus;
	logic [31:0] speed_sat;
	logic        load;
	logic [31:0] load_pos;
	logic [31:0] load_speed;
	logic        load_fresh;

	assign slot_free = !out_valid_q || m_tready;
	assign dticks    = position_q - ref_pos_q;
	assign dus       = q_item.now_us - ref_time_q;
	assign q_pop     = (state_q == ST_IDLE) && q_valid && slot_free;

	// magnitude product feeds the divider register directly
	assign div_req.start    = (state_q == ST_MUL);
	assign div_req.dividend = DIVIDEND_W'(mag_q) * DIVIDEND_W'(US_PER_S);
	assign div_req.divisor  = dus_q;

	// clamp the quotient magnitude into the signed 32-bit range
	always_comb begin
		if (neg_q) begin
			if ((div_quot[DIVIDEND_W-1:32] != '0) || (div_quot[31] && (div_quot[30:0] != '0))) begin
				speed_sat = 32'h8000_0000;
			end else begin
				speed_sat = -div_quot[31:0];
			end
		end else begin
			if (div_quot[DIVIDEND_W-1:31] != '0) begin
				speed_sat = 32'h7fff_ffff;
			end else begin
				speed_sat = div_quot[31:0];
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		load       = 1'b0;
		load_pos   = position_q;
		load_speed = '0;
		load_fresh = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					unique case (q_item.op)
						OP_UP: begin
							load     = 1'b1;
							load_pos = position_q + 32'd1;
						end
						OP_DOWN: begin
							load     = 1'b1;
							load_pos = position_q - 32'd1;
						end
						OP_RESET: begin
							load     = 1'b1;
							load_pos = '0;
						end
						OP_QUERY: begin
							if (dus == '0) begin
								load = 1'b1;
							end else begin
								state_d = ST_MUL;
							end
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					load       = 1'b1;
					load_speed = speed_sat;
					load_fresh = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_pos_q   <= load_pos;
			out_speed_q <= load_speed;
			out_fresh_q <= load_fresh;
		end
		if (q_pop && (q_item.op == OP_QUERY)) begin
			neg_q <= dticks[31];
			mag_q <= dticks[31] ? -dticks : dticks;
			dus_q <= dus;
			now_q <= q_item.now_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			position_q  <= '0;
			ref_pos_q   <= '0;
			ref_time_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				unique case (q_item.op)
					OP_UP:   position_q <= position_q + 32'd1;
					OP_DOWN: position_q <= position_q - 32'd1;
					OP_RESET: begin
						position_q <= '0;
						ref_pos_q  <= '0;
						ref_time_q <= q_item.now_us;
					end
					default: ;
				endcase
			end
			if ((state_q == ST_DONE) && slot_free) begin
				ref_pos_q  <= position_q;
				ref_time_q <= now_q;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_speed_q, out_pos_q};
	assign m_tuser  = out_fresh_q;

endmodule

[design/encoder_position_velocity_top.sv]
// x1 quadrature position counter with velocity estimate. Each input transaction is
// one request (edge, velocity query, count reset, count read) and gives exactly one
// output transaction with the count after it, plus the speed in ticks per second
// and a fresh flag on queries. Requests enter a FIFO_DEPTH-entry queue, so the
// input keeps taking transactions while the back end works or the output stalls,
// until the queue is full. Edges, resets, reads and queries that return zero
// retire at one per cycle while the output is not stalled, passing through the
// request queue and the output register. A computed query holds the back end
// to issue, do the 32x20 multiply, run the divider that resolves two quotient
// bits a cycle over the 52-bit product, see the divider finish and post the result.
module encoder_position_velocity_top import epv_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // b_level, now_us, span_ms, zero fill
	input  logic [1:0]            s_tuser,  // req_type
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // position_count, speed_ticks_per_s
	output logic                  m_tuser   // speed_fresh
);

	logic                  q_valid;
	item_t                 q_item;
	logic                  q_pop;
	div_req_t              div_req;
	logic                  div_done;
	logic [DIVIDEND_W-1:0] div_quot;

	epv_front #(
		.DEPTH (FIFO_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	epv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quot)
	);

	epv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.div_req  (div_req),
		.div_done (div_done),
		.div_quot (div_quot)
	);

endmodule

[design/epv_checker.sv]
`include "assert_macros.svh"

module epv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [55:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tuser
);

	logic [7:0] pend_q;
	logic       in_xact;
	logic       out_xact;

	assign in_xact  = s_tvalid && s_tready;
	assign out_xact = m_tvalid && m_tready;

	// requests taken in minus results handed out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_xact && !out_xact) begin
			pend_q <= pend_q + 8'd1;
		end else if (out_xact && !in_xact) begin
			pend_q <= pend_q - 8'd1;
		end
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`ASSERT_IMPL(a_speed_zero_stale, clk, arst_n, m_tvalid && !m_tuser,
		m_tdata[63:32] == 32'd0)
	`ASSERT_IMPL(a_no_orphan_result, clk, arst_n, m_tvalid, pend_q != 8'd0)

endmodule

bind encoder_position_velocity_top epv_checker u_epv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[bench/tb_encoder_position_velocity_top.sv]
module tb_encoder_position_velocity_top;
	import epv_pkg::*;

	localparam int RAND_ITEMS  = 2000;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 64;
	localparam longint RATE_MAX = 64'sd2147483647;
	localparam longint RATE_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [1:0]  req;
		logic        b;
		logic [31:0] now;
		logic [15:0] win;
	} enc_req_t;

	typedef struct packed {
		logic [31:0] count;
		logic [31:0] speed;
		logic        fresh;
	} enc_res_t;

	// typed = 1 means the expected fields are given in the row
	typedef struct packed {
		logic [1:0]  req;
		logic        b;
		logic [31:0] now;
		logic [15:0] win;
		logic        typed;
		logic [31:0] count;
		logic [31:0] speed;
		logic        fresh;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [21] = '{
		'{REQ_READ,  1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'h0, 32'h0, 1'b0},
		// zero window, then zero elapsed time right after reset
		'{REQ_QUERY, 1'b0, 32'd1000,      16'h0000, 1'b1, 32'h0, 32'h0, 1'b0},
		'{REQ_QUERY, 1'b1, 32'd0,         16'hFFFF, 1'b1, 32'h0, 32'h0, 1'b0},
		// count wraps below zero and back
		'{REQ_EDGE,  1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'h0, 1'b0},
		'{REQ_EDGE,  1'b1, 32'h0,         16'h0000, 1'b1, 32'h0, 32'h0, 1'b0},
		'{REQ_EDGE,  1'b1, 32'h5555_AAAA, 16'hA5A5, 1'b1, 32'd1, 32'h0, 1'b0},
		'{REQ_QUERY, 1'b0, 32'd1000000,   16'd1,    1'b1, 32'd1, 32'd1, 1'b1},
		'{REQ_EDGE,  1'b0, 32'hAAAA_5555, 16'h5A5A, 1'b0, 32'h0, 32'h0, 1'b0},
		'{REQ_EDGE,  1'b0, 32'h0,         16'h0000, 1'b0, 32'h0, 32'h0, 1'b0},
		// negative rate truncates toward zero, window longer than elapsed
		'{REQ_QUERY, 1'b1, 32'd1000003,   16'hFFFF, 1'b0, 32'h0, 32'h0, 1'b0},
		'{REQ_RESET, 1'b0, 32'hFFFF_FFFF, 16'h0000, 1'b1, 32'h0, 32'h0, 1'b0},
		'{REQ_EDGE,  1'b1, 32'h0,         16'h0000, 1'b1, 32'd1, 32'h0, 1'b0},
		// elapsed time wraps past zero
		'{REQ_QUERY, 1'b0, 32'd0,         16'd1,    1'b1, 32'd1, 32'd1000000, 1'b1},
		'{REQ_EDGE,  1'b1, 32'h1234_5678, 16'h8000, 1'b0, 32'h0, 32'h0, 1'b0},
		'{REQ_READ,  1'b0, 32'h0,         16'h0000, 1'b1, 32'd2, 32'h0, 1'b0},
		'{REQ_QUERY, 1'b1, 32'h8000_0000, 16'h8000, 1'b0, 32'h0, 32'h0, 1'b0},
		'{REQ_RESET, 1'b1, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, 32'h0, 32'h0, 1'b0},
		// longest possible elapsed time
		'{REQ_QUERY, 1'b0, 32'h7FFF_FFFE, 16'hFFFF, 1'b0, 32'h0, 32'h0, 1'b0},
		'{REQ_EDGE,  1'b0, 32'h0,         16'h0000, 1'b1, 32'hFFFF_FFFF, 32'h0, 1'b0},
		'{REQ_QUERY, 1'b1, 32'h7FFF_FFFF, 16'd5,    1'b1, 32'hFFFF_FFFF, 32'hFFF0_BDC0, 1'b1},
		'{REQ_QUERY, 1'b0, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'h0, 1'b0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // b_level, now_us, span_ms, zero fill
	logic [1:0]            s_tuser = REQ_EDGE;  // req_type
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // position_count, speed_ticks_per_s
	logic                  m_tuser;         // speed_fresh

	// predictor state
	logic [31:0] pos_cnt = '0;
	logic [31:0] pos_ref = '0;
	logic [31:0] time_ref = '0;

	enc_res_t exp_results_q [$];

	int  n_sent = 0;
	int  n_rand = 0;
	int  n_checked = 0;
	int  n_fresh = 0;
	int  n_clamped = 0;
	int  fail_cnt = 0;
	int  idle_run = 0;
	bit  quiet = 1'b0;
	bit  send_idle_on = 1'b1;
	bit  take_stall_on = 1'b1;
	bit  hold_req = 1'b0;
	bit  hold_done = 1'b0;

	encoder_position_velocity_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic enc_res_t predict_count_speed(enc_req_t r);
		enc_res_t    res;
		logic [31:0] dus;
		logic [31:0] dcnt;
		longint      rate;
		res.speed = '0;
		res.fresh = 1'b0;
		case (r.req)
			REQ_EDGE: begin
				pos_cnt = r.b ? pos_cnt + 32'd1 : pos_cnt - 32'd1;
			end
			REQ_RESET: begin
				pos_cnt = '0;
				pos_ref = '0;
				time_ref = r.now;
			end
			REQ_QUERY: begin
				dus = r.now - time_ref;
				if (r.win != '0 && dus != '0) begin
					dcnt = pos_cnt - pos_ref;
					rate = longint'($signed(dcnt)) * longint'(US_PER_S);
					rate = rate / longint'({32'd0, dus});
					if (rate > RATE_MAX || rate < RATE_MIN) n_clamped++;
					if (rate > RATE_MAX) rate = RATE_MAX;
					if (rate < RATE_MIN) rate = RATE_MIN;
					res.speed = 32'(rate);
					res.fresh = 1'b1;
					pos_ref = pos_cnt;
					time_ref = r.now;
				end
			end
			default: begin
			end
		endcase
		res.count = pos_cnt;
		return res;
	endfunction

	task automatic send_req(input enc_req_t r, input logic typed, input enc_res_t typed_res);
		int       gap;
		enc_res_t res;
		gap = 0;
		if (!quiet && send_idle_on && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.req;
		s_tdata <= {7'd0, r.win, r.now, r.b};
		do @(posedge clk); while (!s_tready);
		res = predict_count_speed(r);
		exp_results_q.push_back(typed ? typed_res : res);
		n_sent++;
		if (n_sent == HOLD_AT) hold_req = 1'b1;
	endtask

	task automatic send(input logic [1:0] req, input logic b, input logic [31:0] now,
			input logic [15:0] win);
		enc_req_t r;
		r.req = req;
		r.b = b;
		r.now = now;
		r.win = win;
		send_req(r, 1'b0, '0);
	endtask

	initial begin : stimulus
		enc_req_t    r;
		enc_res_t    typed_res;
		int          n_edges;
		int          up_bias;
		int          sel;
		logic [31:0] dus;
		logic [15:0] win;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i]) begin
			r.req = DIR_ROWS[i].req;
			r.b = DIR_ROWS[i].b;
			r.now = DIR_ROWS[i].now;
			r.win = DIR_ROWS[i].win;
			typed_res.count = DIR_ROWS[i].count;
			typed_res.speed = DIR_ROWS[i].speed;
			typed_res.fresh = DIR_ROWS[i].fresh;
			send_req(r, DIR_ROWS[i].typed, typed_res);
		end

		while (n_rand < RAND_ITEMS) begin
			if (n_rand >= RAND_ITEMS * 4 / 5) quiet = 1'b1;
			send_idle_on = $urandom_range(0, 2) != 0;
			if ($urandom_range(0, 9) < 7) begin
				// tracking sequence: optional reset, edges with a drift and occasional reads, then a query
				if ($urandom_range(0, 3) == 0) begin
					send(REQ_RESET, 1'($urandom_range(0, 1)), $urandom, 16'($urandom));
					n_rand++;
				end
				n_edges = $urandom_range(0, 30);
				up_bias = $urandom_range(0, 100);
				for (int i = 0; i < n_edges; i++) begin
					if ($urandom_range(0, 7) == 0) begin
						send(REQ_READ, 1'($urandom_range(0, 1)), $urandom, 16'($urandom));
						n_rand++;
					end
					send(REQ_EDGE, $urandom_range(0, 99) < up_bias, $urandom,
						16'($urandom));
					n_rand++;
				end
				sel = $urandom_range(0, 15);
				if (sel == 0) dus = '0;
				else if (sel == 1) dus = $urandom;
				else if (sel <= 3) dus = $urandom_range(1, 4);
				else dus = $urandom_range(1, 200000);
				win = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
				send(REQ_QUERY, 1'($urandom_range(0, 1)), time_ref + dus, win);
				n_rand++;
			end else begin
				repeat ($urandom_range(1, 5)) begin
					send(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom,
						16'($urandom_range(0, 65535)));
					n_rand++;
				end
			end
		end
		s_tvalid <= 1'b0;

		while (exp_results_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("tb: %0d requests sent, %0d results checked", n_sent, n_checked);
		$display("tb: %0d velocity updates, %0d clamped to the 32-bit range",
			n_fresh, n_clamped);
		if (fail_cnt == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin : drain_side
		int cyc;
		cyc = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 256 == 0) take_stall_on = $urandom_range(0, 2) != 0;
			if (hold_req && !hold_done) begin
				// long back-pressure so the request queue fills and s_tready drops
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!quiet && take_stall_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		enc_res_t want;
		enc_res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.count = m_tdata[31:0];
			got.speed = m_tdata[63:32];
			got.fresh = m_tuser;
			if (exp_results_q.size() == 0) begin
				$display("%0t: unexpected transaction count %h speed %h fresh %b",
					$time, got.count, got.speed, got.fresh);
				fail_cnt++;
			end else begin
				want = exp_results_q.pop_front();
				n_checked++;
				if (got.fresh) n_fresh++;
				if (got.count !== want.count) begin
					$display("%0t: position_count expected %h got %h",
						$time, want.count, got.count);
					fail_cnt++;
				end
				if (got.speed !== want.speed) begin
					$display("%0t: speed_ticks_per_s expected %h got %h",
						$time, want.speed, got.speed);
					fail_cnt++;
				end
				if (got.fresh !== want.fresh) begin
					$display("%0t: speed_fresh expected %b got %b",
						$time, want.fresh, got.fresh);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_run <= 0;
			else
				idle_run <= idle_run + 1;
			if (idle_run == STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

endmodule
